// ----- rtl/core/slm_pkg.sv -----
package slm_pkg;

  // Default table depth and depth of the queue between front and back
  localparam int unsigned TABLE_ENTRIES_DEF = 64;
  localparam int unsigned QUEUE_DEPTH       = 2;

  // Event classes seen by the back end
  typedef enum logic [0:0] {
    OP_TX = 1'b0,
    OP_RX = 1'b1
  } op_t;

  // Input transaction as seen on the port
  typedef struct packed {
    logic        kind;
    logic [31:0] seq_number;
    logic [47:0] time_ns;
  } in_t;

  // Result transaction
  typedef struct packed {
    logic        matched;
    logic [47:0] delay_ns;
    logic        stored;
    logic        table_full;
    logic [63:0] delay_total;
    logic [31:0] match_total;
  } out_t;

  // Classified event held in the queue
  typedef struct packed {
    op_t         op;
    logic [31:0] seq_number;
    logic [47:0] time_ns;
  } q_item_t;

  // One table entry
  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [47:0] time_ns;
  } entry_t;

endpackage

// ----- rtl/core/slm_queue.sv -----
module slm_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  slm_pkg::in_t    in_data,
  output logic            q_valid,
  output slm_pkg::q_item_t q_item,
  input  logic            q_pop
);

  localparam int unsigned PW = (slm_pkg::QUEUE_DEPTH > 1) ? $clog2(slm_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(slm_pkg::QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(slm_pkg::QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(slm_pkg::QUEUE_DEPTH);

  slm_pkg::q_item_t items [slm_pkg::QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             push;
  logic             pop;
  slm_pkg::q_item_t cls_item;

  assign in_stall = (count == CNT_FULL);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign pop      = q_pop && q_valid;
  assign q_item   = items[rd_ptr];

  // Classify the incoming event
  always_comb begin
    cls_item.op         = in_data.kind ? slm_pkg::OP_RX : slm_pkg::OP_TX;
    cls_item.seq_number = in_data.seq_number;
    cls_item.time_ns    = in_data.time_ns;
  end

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      items[wr_ptr] <= cls_item;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/core/slm_engine.sv -----
module slm_engine #(
  parameter int unsigned TABLE_ENTRIES = slm_pkg::TABLE_ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  slm_pkg::q_item_t q_item,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output slm_pkg::out_t    out_data
);

  localparam int unsigned   AW   = $clog2(TABLE_ENTRIES);
  localparam logic [AW-1:0] LAST = AW'(TABLE_ENTRIES - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_UPDATE,
    S_FINISH
  } state_t;

  state_t            state;
  slm_pkg::entry_t   mem [TABLE_ENTRIES];
  slm_pkg::entry_t   rd_data;
  slm_pkg::entry_t   wr_data;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     clr_addr;
  logic [AW-1:0]     rd_addr;
  logic              issue_done;
  logic              chk_vld;
  logic [AW-1:0]     chk_idx;
  logic              chk_hit;
  logic              chk_free;
  slm_pkg::q_item_t  cur;
  logic              hit;
  logic [AW-1:0]     hit_idx;
  logic [47:0]       hit_time;
  logic              free_found;
  logic [AW-1:0]     free_idx;
  logic              res_matched;
  logic              res_stored;
  logic              res_full;
  logic [47:0]       res_delay;
  logic [63:0]       delay_sum;
  logic [31:0]       match_count;
  logic [64:0]       sum_ext;
  logic [63:0]       sum_sat;
  logic [31:0]       cnt_next;
  logic              is_tx;

  assign q_pop = (state == S_IDLE) && q_valid;
  assign is_tx = (cur.op == slm_pkg::OP_TX);

  // Compare of the entry returned by the table read
  assign chk_hit  = chk_vld && rd_data.valid && (rd_data.key == cur.seq_number);
  assign chk_free = chk_vld && !rd_data.valid;

  // Saturating accumulators
  assign sum_ext  = {1'b0, delay_sum} + {17'd0, res_delay};
  assign sum_sat  = sum_ext[64] ? '1 : sum_ext[63:0];
  assign cnt_next = (match_count == '1) ? match_count : match_count + 1'b1;

  // Table write port: clearing pass, store or free
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_addr;
    wr_data = '0;
    case (state)
      S_CLEAR: begin
        wr_en = 1'b1;
      end
      S_UPDATE: begin
        if (is_tx) begin
          wr_data.valid   = 1'b1;
          wr_data.key     = cur.seq_number;
          wr_data.time_ns = cur.time_ns;
          if (hit) begin
            wr_en   = 1'b1;
            wr_addr = hit_idx;
          end else if (free_found) begin
            wr_en   = 1'b1;
            wr_addr = free_idx;
          end
        end else if (hit) begin
          wr_en   = 1'b1;
          wr_addr = hit_idx;
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Table memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Sequencer, scan engine and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      rd_addr     <= '0;
      issue_done  <= 1'b0;
      chk_vld     <= 1'b0;
      out_valid   <= 1'b0;
      delay_sum   <= '0;
      match_count <= '0;
    end else begin
      // the finish state loads the result register itself
      if (out_valid && !out_stall && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            cur        <= q_item;
            rd_addr    <= '0;
            issue_done <= 1'b0;
            chk_vld    <= 1'b0;
            hit        <= 1'b0;
            free_found <= 1'b0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          // issue side
          chk_vld <= !issue_done;
          chk_idx <= rd_addr;
          if (!issue_done) begin
            if (rd_addr == LAST) begin
              issue_done <= 1'b1;
            end else begin
              rd_addr <= rd_addr + 1'b1;
            end
          end
          // compare side; keys are unique, so a hit ends the scan
          if (chk_hit) begin
            hit      <= 1'b1;
            hit_idx  <= chk_idx;
            hit_time <= rd_data.time_ns;
            state    <= S_UPDATE;
          end else begin
            if (chk_free && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= chk_idx;
            end
            if (chk_vld && (chk_idx == LAST)) begin
              state <= S_UPDATE;
            end
          end
        end
        S_UPDATE: begin
          res_matched <= !is_tx && hit;
          res_stored  <= is_tx && (hit || free_found);
          res_full    <= is_tx && !hit && !free_found;
          if (!is_tx && hit && (cur.time_ns >= hit_time)) begin
            res_delay <= cur.time_ns - hit_time;
          end else begin
            res_delay <= '0;
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid || !out_stall) begin
            out_valid            <= 1'b1;
            out_data.matched     <= res_matched;
            out_data.delay_ns    <= res_delay;
            out_data.stored      <= res_stored;
            out_data.table_full  <= res_full;
            out_data.delay_total <= res_matched ? sum_sat : delay_sum;
            out_data.match_total <= res_matched ? cnt_next : match_count;
            if (res_matched) begin
              delay_sum   <= sum_sat;
              match_count <= cnt_next;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/sequence_latency_matcher.sv -----
// Transmit/receive latency matcher. A transmit transaction records its
// timestamp under its sequence number in a TABLE_ENTRIES-deep table (an
// existing key is overwritten, otherwise the lowest free entry is taken, or
// the event is dropped with table_full set); a receive transaction looks its
// key up, reports the delay, frees the entry and updates the saturating
// delay sum and match count. Every input gives exactly one result. After
// reset the table is cleared in a pass over all TABLE_ENTRIES entries, during
// which inputs are only queued. In the back end the key search walks the
// table one entry per cycle through its single read port; a receive or
// retransmit hit ends the scan early. A two-deep queue at the input and
// the result register let either side stall independently.
module sequence_latency_matcher #(
  parameter int unsigned TABLE_ENTRIES = slm_pkg::TABLE_ENTRIES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  slm_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output slm_pkg::out_t out_data
);

  logic             q_valid;
  logic             q_pop;
  slm_pkg::q_item_t q_item;

  // Front: accept and classify
  slm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // Back: table search, update and accumulation
  slm_engine #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/core/slm_checker.sv -----
module slm_checker (
  input logic          clk,
  input logic          rst,
  input logic          out_valid,
  input logic          out_stall,
  input slm_pkg::out_t out_data
);

  // No result straight after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // At most one outcome class per result
  a_one_outcome: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($countones({out_data.matched, out_data.stored, out_data.table_full}) <= 1))
    else $error("more than one outcome flag set");

  // Delay is zero unless matched
  a_delay_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.matched |-> (out_data.delay_ns == '0))
    else $error("delay without match");

  // A match always leaves a non-zero count
  a_count_nz: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.matched |-> (out_data.match_total != '0))
    else $error("match with zero count");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind sequence_latency_matcher slm_checker u_slm_checker (.*);
